FILE: design/pfvu_pkg.sv
package pfvu_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_PARAM    = 2'd0;
	localparam logic [1:0] KIND_SUM_OK   = 2'd1;
	localparam logic [1:0] KIND_SUM_BAD  = 2'd2;

	// Voice layout.
	localparam logic [6:0] GLOBAL_START  = 7'd102;
	localparam logic [7:0] GLOBAL_INDEX  = 8'd126;
	localparam logic [7:0] ENABLE_INDEX  = 8'd155;
	localparam logic [7:0] ENABLE_VALUE  = 8'h3f;
	localparam logic [6:0] LAST_POSITION = 7'd127;

	// One unpacked image entry.
	typedef struct packed {
		logic [7:0] idx;
		logic [7:0] val;
	} entry_t;

	// Everything one payload word produces.
	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] voice;
		logic [1:0] cnt;
		entry_t [2:0] res;
	} decode_t;

endpackage

FILE: design/pfvu_decode.sv
module pfvu_decode import pfvu_pkg::*; #(
	parameter int BANK_VOICES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  data_byte,
	input  logic        first,
	input  logic        is_checksum,
	output decode_t     dec
);

	logic [6:0] pos_q;
	logic [4:0] voice_q;
	logic [3:0] detune_q;
	logic [6:0] sum_q;

	logic [6:0] pos_eff;
	logic [4:0] voice_eff;
	logic [6:0] sum_eff;
	logic [6:0] expect_sum;
	logic [6:0] op_start;
	logic [6:0] op_diff;
	logic [4:0] k;
	logic [7:0] base;
	logic [6:0] g_diff;
	logic [4:0] g;
	logic [7:0] b;
	logic       in_ops;
	logic       take_detune;
	logic [6:0] pos_d;
	logic [4:0] voice_d;
	logic [5:0] voice_inc;

	// A first word clears position, voice count and sum before it is used.
	assign pos_eff    = first ? '0 : pos_q;
	assign voice_eff  = first ? '0 : voice_q;
	assign sum_eff    = first ? '0 : sum_q;
	assign expect_sum = 7'(7'd0 - sum_eff);
	assign b          = data_byte;
	assign in_ops     = pos_eff < GLOBAL_START;

	// Split the position into operator and byte within the operator block.
	always_comb begin
		if (pos_eff >= 7'd85) begin
			op_start = 7'd85;
			base     = 8'd105;
		end else if (pos_eff >= 7'd68) begin
			op_start = 7'd68;
			base     = 8'd84;
		end else if (pos_eff >= 7'd51) begin
			op_start = 7'd51;
			base     = 8'd63;
		end else if (pos_eff >= 7'd34) begin
			op_start = 7'd34;
			base     = 8'd42;
		end else if (pos_eff >= 7'd17) begin
			op_start = 7'd17;
			base     = 8'd21;
		end else begin
			op_start = 7'd0;
			base     = 8'd0;
		end
	end

	assign op_diff = pos_eff - op_start;
	assign k       = op_diff[4:0];
	assign g_diff  = pos_eff - GLOBAL_START;
	assign g       = g_diff[4:0];

	// Field extraction for the current word.
	always_comb begin
		dec       = '0;
		dec.kind  = KIND_PARAM;
		dec.voice = voice_eff;
		dec.cnt   = 2'd1;
		take_detune = 1'b0;
		if (is_checksum) begin
			dec.kind       = (b == {1'b0, expect_sum}) ? KIND_SUM_OK : KIND_SUM_BAD;
			dec.res[0].val = {1'b0, expect_sum};
		end else if (in_ops) begin
			case (k) inside
				[5'd0:5'd10]: begin
					dec.res[0] = '{base + {3'b0, k}, b};
				end
				5'd11: begin
					dec.cnt    = 2'd2;
					dec.res[0] = '{base + 8'd11, {6'b0, b[1:0]}};
					dec.res[1] = '{base + 8'd12, {6'b0, b[3:2]}};
				end
				5'd12: begin
					dec.res[0]  = '{base + 8'd13, {5'b0, b[2:0]}};
					take_detune = 1'b1;
				end
				5'd13: begin
					dec.cnt    = 2'd2;
					dec.res[0] = '{base + 8'd14, {6'b0, b[1:0]}};
					dec.res[1] = '{base + 8'd15, {5'b0, b[4:2]}};
				end
				5'd14: begin
					dec.res[0] = '{base + 8'd16, b};
				end
				5'd15: begin
					dec.cnt    = 2'd2;
					dec.res[0] = '{base + 8'd17, {7'b0, b[0]}};
					dec.res[1] = '{base + 8'd18, {3'b0, b[5:1]}};
				end
				default: begin
					dec.cnt    = 2'd2;
					dec.res[0] = '{base + 8'd19, b};
					dec.res[1] = '{base + 8'd20, {4'b0, detune_q}};
				end
			endcase
		end else begin
			case (g) inside
				[5'd0:5'd7]: begin
					dec.res[0] = '{GLOBAL_INDEX + {3'b0, g}, b};
				end
				5'd8: begin
					dec.res[0] = '{8'd134, {3'b0, b[4:0]}};
				end
				5'd9: begin
					dec.cnt    = 2'd2;
					dec.res[0] = '{8'd135, {5'b0, b[2:0]}};
					dec.res[1] = '{8'd136, {7'b0, b[3]}};
				end
				[5'd10:5'd13]: begin
					dec.res[0] = '{8'd127 + {3'b0, g}, b};
				end
				5'd14: begin
					dec.cnt    = 2'd3;
					dec.res[0] = '{8'd141, {7'b0, b[0]}};
					dec.res[1] = '{8'd142, {5'b0, b[3:1]}};
					dec.res[2] = '{8'd143, {5'b0, b[6:4]}};
				end
				5'd15: begin
					dec.res[0] = '{8'd144, b};
				end
				5'd25: begin
					dec.cnt    = 2'd2;
					dec.res[0] = '{8'd129 + {3'b0, g}, b};
					dec.res[1] = '{ENABLE_INDEX, ENABLE_VALUE};
				end
				default: begin
					dec.res[0] = '{8'd129 + {3'b0, g}, b};
				end
			endcase
		end
	end

	// Position and voice advance; the voice count wraps at the bank size.
	assign voice_inc = {1'b0, voice_eff} + 6'd1;

	always_comb begin
		pos_d   = pos_eff + 7'd1;
		voice_d = voice_eff;
		if (pos_eff == LAST_POSITION) begin
			pos_d   = '0;
			voice_d = (voice_inc >= 6'(BANK_VOICES)) ? '0 : voice_inc[4:0];
		end
	end

	// Running state; a checksum word only applies the clear of a first word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			voice_q  <= '0;
			detune_q <= '0;
			sum_q    <= '0;
		end else if (en) begin
			if (is_checksum) begin
				pos_q   <= pos_eff;
				voice_q <= voice_eff;
				sum_q   <= sum_eff;
			end else begin
				pos_q   <= pos_d;
				voice_q <= voice_d;
				sum_q   <= sum_eff + b[6:0];
				if (take_detune) begin
					detune_q <= b[6:3];
				end
			end
		end
	end

endmodule

FILE: design/packed_fm_voice_unpacker_core.sv
// Flow: a word waits in the input register and is decoded into the result register,
// which shows its first result; a word gives one to three results. Unless out_stall
// holds it, that register hands out one entry a cycle and reloads on the last one.
// Reset: arst_n clears position, voice count, detune, sum and all valid flags
// at once; no clearing pass is needed.
module packed_fm_voice_unpacker_core import pfvu_pkg::*; #(
	parameter int BANK_VOICES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       first,
	input  logic       is_checksum,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [4:0] voice_index,
	output logic [7:0] param_index,
	output logic [7:0] param_value,
	output logic       last
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       cs_s1;

	decode_t    dec;
	logic       load;
	logic       out_take;

	logic       ovalid_q;
	logic [1:0] kind_q;
	logic [4:0] voice_q;
	logic [1:0] cnt_q;
	logic [1:0] ptr_q;
	entry_t     res_q [3];

	// The result register frees up when its last entry is taken.
	assign out_take = ovalid_q && !out_stall;
	assign load     = valid_s1 && (!ovalid_q || (out_take && last));
	assign in_stall = valid_s1 && !load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1  <= data_byte;
			first_s1 <= first;
			cs_s1    <= is_checksum;
		end
	end

	pfvu_decode #(
		.BANK_VOICES(BANK_VOICES)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (load),
		.data_byte   (data_s1),
		.first       (first_s1),
		.is_checksum (cs_s1),
		.dec         (dec)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			ptr_q    <= '0;
		end else if (load) begin
			ovalid_q <= 1'b1;
			ptr_q    <= '0;
		end else if (out_take) begin
			if (last) begin
				ovalid_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= dec.kind;
			voice_q  <= dec.voice;
			cnt_q    <= dec.cnt;
			res_q[0] <= dec.res[0];
			res_q[1] <= dec.res[1];
			res_q[2] <= dec.res[2];
		end
	end

	assign out_valid   = ovalid_q;
	assign kind        = kind_q;
	assign voice_index = voice_q;
	assign param_index = res_q[ptr_q].idx;
	assign param_value = res_q[ptr_q].val;
	assign last        = (ptr_q == cnt_q - 2'd1);

`ifndef ASSERT_OFF
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ptr_q < cnt_q))
		else $error("Result pointer beyond the word's result count.");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_PARAM) |-> (last && ptr_q == 2'd0))
		else $error("Checksum status is not a single result.");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_valid && ptr_q == 2'd0))
		else $error("A new word did not restart the result pointer.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ptr_q)))
		else $error("Stalled result pointer moved.");
`endif

endmodule
